// File: rtl/core/csac_pkg.sv
// Shared types and codes for the credit slot admission controller.
`timescale 1ns / 1ps
package csac_pkg;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_ADMIT    = 3'd1;
    localparam logic [2:0] ACT_CREDIT   = 3'd2;
    localparam logic [2:0] ACT_CANCEL   = 3'd3;
    localparam logic [2:0] ACT_SHUTDOWN = 3'd4;
    localparam logic [2:0] ACT_BAD      = 3'd7;

    localparam logic [3:0] K_ADMIT   = 4'd0;
    localparam logic [3:0] K_COMMIT  = 4'd1;
    localparam logic [3:0] K_DONE    = 4'd2;
    localparam logic [3:0] K_CANCEL  = 4'd3;
    localparam logic [3:0] K_CREDIT  = 4'd4;
    localparam logic [3:0] K_QUIET   = 4'd5;
    localparam logic [3:0] K_DUP     = 4'd6;
    localparam logic [3:0] K_REJECT  = 4'd7;
    localparam logic [3:0] K_SHUT    = 4'd8;

    localparam logic [3:0] S_OK        = 4'd0;
    localparam logic [3:0] S_OWNER     = 4'd1;
    localparam logic [3:0] S_STALE     = 4'd2;
    localparam logic [3:0] S_FULL      = 4'd3;
    localparam logic [3:0] S_GEN       = 4'd4;
    localparam logic [3:0] S_ROW       = 4'd5;
    localparam logic [3:0] S_TARGET    = 4'd6;
    localparam logic [3:0] S_CREDIT    = 4'd7;
    localparam logic [3:0] S_STALE_CAN = 4'd8;
    localparam logic [3:0] S_INACTIVE  = 4'd9;
    localparam logic [3:0] S_UNKNOWN   = 4'd10;
    localparam logic [3:0] S_MALFORMED = 4'd11;
    localparam logic [3:0] S_DUP       = 4'd12;
    localparam logic [3:0] S_BUSY      = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT,
        ST_HALT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;     // latch input item
        logic decide;   // evaluate event, update state, queue results
        logic scan;     // tick: process one row
        logic pop;      // drop the head result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic scan_last;
        logic queue_empty;
        logic halt;
    } t_stat;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] seq;
        logic [31:0] req;
        logic [31:0] gen;
        logic [7:0]  row;
        logic [31:0] commits;
        logic [32:0] value;
        logic [32:0] rem;
        logic [32:0] credit;
        logic [32:0] cancel;
        logic [3:0]  status;
    } t_res;

endpackage

// File: rtl/core/csac_ctrl.sv
// Controller state machine for the credit slot admission controller.
`timescale 1ns / 1ps
module csac_ctrl
    import csac_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    input  logic  i_out_ready,
    output logic  o_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_stat.is_tick) begin
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.decide = 1'b1;
                    n_state      = ST_EMIT;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.queue_empty) begin
                    n_state = i_stat.halt ? ST_HALT : ST_IDLE;
                end else begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) o_cmd.pop = 1'b1;
                end
            end
            ST_HALT: begin
                o_ready = 1'b1;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/core/csac_dp.sv
// Slot table, event checks and result queue of the admission controller.
`timescale 1ns / 1ps
module csac_dp
    import csac_pkg::*;
#(
    parameter int ROWS      = 4,
    parameter int MAX_STEPS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_event_owner,
    input  logic [31:0] i_event_seq,
    input  logic [31:0] i_request_id,
    input  logic [31:0] i_generation,
    input  logic [7:0]  i_slot_row,
    input  logic [15:0] i_target_steps,
    input  logic [15:0] i_credit_amount,
    input  logic [31:0] i_cancel_number,
    input  logic [32:0] i_seed_value,
    input  logic [31:0] i_flag_word,
    input  logic [31:0] i_spare_word,
    output t_res        o_head,
    output logic        o_last
);

    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW  = $clog2(MAX_STEPS + 1);
    localparam int QD  = 2 * ROWS + 1;
    localparam int QW  = $clog2(QD + 1);
    localparam int EW  = 3 + 16 + 32 * 3 + 8 + 16 + 16 + 32 + 33 + 32 + 32;

    logic [15:0] r_owner;
    logic [EW-1:0] r_ev, r_prev;
    logic r_have_prev;
    logic [31:0] r_last_seq;
    logic [7:0]  r_touched;
    logic [31:0] r_ticks, r_tcommits, r_tevents, r_tdups, r_tcancels;
    logic r_halt;

    logic [ROWS-1:0] r_act;
    logic [31:0] r_req [ROWS];
    logic [31:0] r_gen [ROWS];
    logic [31:0] r_lgen [ROWS];
    logic [SW-1:0] r_tgt [ROWS];
    logic [SW-1:0] r_cred [ROWS];
    logic [SW-1:0] r_cmt [ROWS];
    logic [31:0] r_val [ROWS];
    logic [31:0] r_lcan [ROWS];

    t_res r_q [QD];
    logic [QW-1:0] r_qn, r_qh;
    logic [RW-1:0] r_scan;
    logic [ROWS-1:0] r_elig;
    logic r_qrow_ok;
    logic [RW-1:0] r_qrow;

    // unpacked event fields
    logic [2:0]  e_act;
    logic [15:0] e_owner;
    logic signed [31:0] e_seq, e_req, e_gen, e_cancel;
    logic signed [7:0]  e_row;
    logic signed [15:0] e_tgt, e_cred;
    logic signed [32:0] e_seed;
    assign {e_act, e_owner, e_seq, e_req, e_gen, e_row, e_tgt, e_cred, e_cancel, e_seed}
        = r_ev[EW-1:64];

    assign o_head = r_q[r_qh[QW-1:0] < QW'(QD) ? r_qh : '0];
    assign o_last = (r_qh + QW'(1)) == r_qn;
    assign o_stat.is_tick     = (e_act == ACT_TICK);
    assign o_stat.scan_last   = (r_scan == RW'(ROWS - 1));
    assign o_stat.queue_empty = (r_qh == r_qn);
    assign o_stat.halt        = r_halt;

    function automatic t_res row_res(input logic [3:0] k, input logic [31:0] s,
                                     input int r, input logic [31:0] c, input logic [3:0] st,
                                     input logic [31:0] rq, input logic [31:0] gn,
                                     input logic [SW-1:0] cm, input logic [31:0] vl,
                                     input logic [SW-1:0] tg, input logic [SW-1:0] cr);
        t_res x;
        x.kind = k; x.seq = s; x.req = rq; x.gen = gn; x.row = 8'(r);
        x.commits = 32'(cm);
        x.value   = {vl[31], vl};
        x.rem     = 33'(signed'({1'b0, tg}) - signed'({1'b0, cm}));
        x.credit  = 33'(cr);
        x.cancel  = {c[31], c};
        x.status  = st;
        return x;
    endfunction

    // decide logic
    logic rowok, dup;
    logic [RW-1:0] ri;
    t_res d_res [2];
    logic [1:0] d_n;
    logic d_admit, d_credit, d_cancel, d_shut, d_accept;
    logic [RW-1:0] d_got;
    logic [SW:0] d_sum;
    logic signed [33:0] seedmax;
    logic busy_a, free_a, got_ok;
    logic [3:0] st;

    always_comb begin
        t_res rej;
        rowok   = (e_row >= 0) && (e_row < ROWS);
        ri      = RW'(e_row[6:0]);
        dup     = r_have_prev && (r_ev == r_prev);
        d_n = 2'd0; d_res[0] = '0; d_res[1] = '0;
        d_admit = 1'b0; d_credit = 1'b0; d_cancel = 1'b0; d_shut = 1'b0; d_accept = 1'b0;
        d_got = '0; busy_a = 1'b0; free_a = 1'b0; got_ok = 1'b0; st = S_OK;
        d_sum = (SW+1)'(r_cred[ri]) + (SW+1)'(e_cred[SW-1:0]);
        seedmax = 34'sd2147483647 - 34'(e_tgt);
        for (int i = 0; i < ROWS; i++) begin
            if (r_act[i] && (r_req[i] == e_req || r_gen[i] == e_gen)) busy_a = 1'b1;
        end
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!r_act[i]) begin
                free_a = 1'b1;
                if (e_gen > signed'(r_lgen[i])) begin got_ok = 1'b1; d_got = RW'(i); end
            end
        end
        if (rowok)
            rej = row_res(K_REJECT, e_seq, int'(e_row), e_cancel, S_OK, r_req[ri], r_gen[ri],
                          r_cmt[ri], r_val[ri], r_tgt[ri], r_cred[ri]);
        else begin
            rej = '0; rej.kind = K_REJECT; rej.seq = e_seq; rej.req = e_req; rej.gen = e_gen;
            rej.row = e_row; rej.value = e_seed; rej.rem = 33'(e_tgt);
            rej.credit = 33'(e_cred); rej.cancel = 33'(e_cancel);
        end
        if (e_act == ACT_BAD) begin
            d_n = 2'd1; d_res[0] = '0; d_res[0].kind = K_REJECT; d_res[0].seq = r_last_seq;
            d_res[0].row = 8'hFF; d_res[0].status = S_MALFORMED;
        end else if (e_owner != r_owner) begin
            d_n = 2'd1; d_res[0] = rej; d_res[0].status = S_OWNER;
        end else if (dup && e_seq == signed'(r_last_seq)) begin
            d_n = 2'd1;
            if (!r_touched[7] && r_touched < 8'(ROWS)) begin
                d_res[0] = row_res(K_DUP, e_seq, int'(r_touched), e_cancel, S_DUP,
                    r_req[RW'(r_touched)], r_gen[RW'(r_touched)], r_cmt[RW'(r_touched)],
                    r_val[RW'(r_touched)], r_tgt[RW'(r_touched)], r_cred[RW'(r_touched)]);
            end else begin
                d_res[0] = rej; d_res[0].kind = K_DUP; d_res[0].status = S_DUP;
                d_res[0].req = e_req; d_res[0].gen = e_gen; d_res[0].row = e_row;
                d_res[0].commits = '0; d_res[0].value = e_seed; d_res[0].rem = 33'(e_tgt);
                d_res[0].credit = 33'(e_cred); d_res[0].cancel = 33'(e_cancel);
            end
        end else if (e_seq <= signed'(r_last_seq)) begin
            d_n = 2'd1; d_res[0] = rej; d_res[0].status = S_STALE;
        end else begin
            d_accept = 1'b1; d_n = 2'd1; d_res[0] = rej;
            priority case (e_act)
                ACT_ADMIT: begin
                    if (e_req <= 0 || e_gen <= 0 || e_row != -8'sd1 || e_tgt <= 0 ||
                        e_tgt > MAX_STEPS || e_cred < 0 || e_cred > e_tgt ||
                        e_seed < -33'sd2147483648 || 34'(e_seed) > seedmax) st = S_TARGET;
                    else if (busy_a) st = S_BUSY;
                    else if (!got_ok) st = free_a ? S_GEN : S_FULL;
                    if (st == S_OK) begin
                        d_admit = 1'b1;
                        d_res[0] = row_res(K_ADMIT, e_seq, int'(d_got), 32'd0, S_OK, e_req,
                            e_gen, '0, e_seed[31:0], SW'(e_tgt), SW'(e_cred));
                    end else d_res[0].status = st;
                end
                ACT_CREDIT: begin
                    if (!rowok) st = S_ROW;
                    else if (!r_act[ri]) st = S_INACTIVE;
                    else if (r_req[ri] != e_req || r_gen[ri] != e_gen) st = S_GEN;
                    else if (e_cred <= 0 || d_sum > (SW+1)'(r_tgt[ri] - r_cmt[ri]) ||
                             e_cred > 16'(MAX_STEPS)) st = S_CREDIT;
                    if (st == S_OK) begin
                        d_credit = 1'b1;
                        d_res[0] = row_res(K_CREDIT, e_seq, int'(e_row), 32'd0, S_OK,
                            r_req[ri], r_gen[ri], r_cmt[ri], r_val[ri], r_tgt[ri],
                            SW'(d_sum));
                    end else d_res[0].status = st;
                end
                ACT_CANCEL: begin
                    if (!rowok) st = S_ROW;
                    else if (!r_act[ri])
                        st = (r_req[ri] == e_req && r_gen[ri] == e_gen) ? S_INACTIVE : S_GEN;
                    else if (r_req[ri] != e_req || r_gen[ri] != e_gen) st = S_GEN;
                    else if (e_cancel <= 0 || e_cancel <= signed'(r_lcan[ri])) st = S_STALE_CAN;
                    if (st == S_OK) begin
                        d_cancel = 1'b1;
                        d_res[0] = row_res(K_CANCEL, e_seq, int'(e_row), e_cancel, S_OK,
                            r_req[ri], r_gen[ri], r_cmt[ri], r_val[ri], r_tgt[ri],
                            r_cred[ri]);
                        if ((r_act & ~(ROWS'(1) << ri)) == '0) begin
                            d_n = 2'd2; d_res[1] = d_res[0]; d_res[1].kind = K_QUIET;
                            d_res[1].cancel = '0;
                        end
                    end else d_res[0].status = st;
                end
                ACT_SHUTDOWN: begin
                    if (r_act != '0) d_res[0].status = S_BUSY;
                    else begin
                        d_shut = 1'b1; d_res[0] = '0; d_res[0].kind = K_SHUT;
                        d_res[0].seq = e_seq; d_res[0].row = 8'hFF;
                        d_res[0].commits = r_ticks; d_res[0].value = {1'b0, r_tcommits};
                        d_res[0].rem = {1'b0, r_tevents + 32'd1};
                        d_res[0].credit = {1'b0, r_tdups}; d_res[0].cancel = {1'b0, r_tcancels};
                    end
                end
                default: d_res[0].status = S_UNKNOWN;
            endcase
        end
    end

    // tick row step
    logic [SW-1:0] t_cmt, t_cred;
    logic [31:0] t_val;
    logic t_done;
    always_comb begin
        t_cmt  = r_cmt[r_scan] + SW'(1);
        t_cred = r_cred[r_scan] - SW'(1);
        t_val  = r_val[r_scan] + 32'd1;
        t_done = (t_cmt == r_tgt[r_scan]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= 16'd1; r_have_prev <= 1'b0; r_last_seq <= '0; r_touched <= 8'hFF;
            r_ticks <= '0; r_tcommits <= '0; r_tevents <= '0; r_tdups <= '0;
            r_tcancels <= '0; r_halt <= 1'b0; r_act <= '0; r_qn <= '0; r_qh <= '0;
            r_scan <= '0; r_prev <= '0;
            for (int i = 0; i < ROWS; i++) begin
                r_req[i] <= '0; r_gen[i] <= '0; r_lgen[i] <= '0; r_tgt[i] <= '0;
                r_cred[i] <= '0; r_cmt[i] <= '0; r_val[i] <= '0; r_lcan[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) r_owner <= i_cfg_data;
            if (i_cmd.take) begin
                r_ev <= {i_action, i_event_owner, i_event_seq, i_request_id, i_generation,
                         i_slot_row, i_target_steps, i_credit_amount, i_cancel_number,
                         i_seed_value, i_flag_word, i_spare_word};
                r_qn <= '0; r_qh <= '0; r_scan <= '0; r_qrow_ok <= 1'b0;
                for (int i = 0; i < ROWS; i++) r_elig[i] <= r_act[i] && r_cred[i] != '0;
            end
            if (i_cmd.pop) r_qh <= r_qh + QW'(1);
            if (i_cmd.decide) begin
                r_q[0] <= d_res[0]; r_q[1] <= d_res[1]; r_qn <= QW'(d_n);
                if (e_act != ACT_BAD && e_owner == r_owner && dup &&
                    e_seq == signed'(r_last_seq)) r_tdups <= r_tdups + 32'd1;
                if (d_accept) begin
                    r_prev <= r_ev; r_have_prev <= 1'b1; r_last_seq <= e_seq;
                    r_touched <= d_admit ? 8'(d_got) : e_row;
                    r_tevents <= r_tevents + 32'd1;
                end
                if (d_admit) begin
                    r_act[d_got] <= 1'b1; r_req[d_got] <= e_req; r_gen[d_got] <= e_gen;
                    r_lgen[d_got] <= e_gen; r_tgt[d_got] <= SW'(e_tgt);
                    r_cred[d_got] <= SW'(e_cred); r_cmt[d_got] <= '0;
                    r_val[d_got] <= e_seed[31:0]; r_lcan[d_got] <= '0;
                end
                if (d_credit) r_cred[ri] <= SW'(d_sum);
                if (d_cancel) begin
                    r_lcan[ri] <= e_cancel; r_act[ri] <= 1'b0;
                    r_tcancels <= r_tcancels + 32'd1;
                end
                if (d_shut) r_halt <= 1'b1;
            end
            if (i_cmd.scan) begin
                automatic logic [QW-1:0] n = r_qn;
                automatic logic [ROWS-1:0] still = r_act;
                automatic logic ok = r_qrow_ok;
                automatic logic [RW-1:0] qr = r_qrow;
                r_scan <= r_scan + RW'(1);
                if (r_scan == '0 && r_elig != '0) r_ticks <= r_ticks + 32'd1;
                if (r_elig[r_scan]) begin
                    r_val[r_scan] <= t_val; r_cmt[r_scan] <= t_cmt; r_cred[r_scan] <= t_cred;
                    r_tcommits <= r_tcommits + 32'd1;
                    r_q[n] <= row_res(K_COMMIT, r_last_seq, int'(r_scan), 32'd0, S_OK,
                        r_req[r_scan], r_gen[r_scan], t_cmt, t_val, r_tgt[r_scan], t_cred);
                    n = n + QW'(1);
                    if (t_done) begin
                        r_act[r_scan] <= 1'b0;
                        r_q[n] <= row_res(K_DONE, r_last_seq, int'(r_scan), 32'd0,
                            S_OK, r_req[r_scan], r_gen[r_scan], t_cmt, t_val, r_tgt[r_scan],
                            t_cred);
                        n = n + QW'(1);
                        r_qrow_ok <= 1'b1; r_qrow <= r_scan;
                        still[r_scan] = 1'b0; ok = 1'b1; qr = r_scan;
                    end
                end
                if (o_stat.scan_last && ok && still == '0) begin
                    r_q[n] <= row_res(K_QUIET, r_last_seq, int'(qr), 32'd0, S_OK,
                        r_req[qr], r_gen[qr], (qr == r_scan && r_elig[r_scan]) ? t_cmt
                        : r_cmt[qr], (qr == r_scan && r_elig[r_scan]) ? t_val : r_val[qr],
                        r_tgt[qr], (qr == r_scan && r_elig[r_scan]) ? t_cred
                        : r_cred[qr]);
                    n = n + QW'(1);
                end
                r_qn <= n;
            end
        end
    end

endmodule

// File: rtl/core/credit_slot_admission_controller.sv
// Top level of the credit slot admission controller.
// Usage:
//  Input channel (i_valid/o_ready) carries one event or tick per item.
//  Output channel (o_valid/i_ready) delivers results; o_last marks the
//  final result of an item. A tick may produce no result at all.
//  Config channel (i_cfg_valid/o_cfg_ready) writes the owner identity.
//  Flow: an event passes idle, decide and emit; a tick passes idle, decide,
//  scan (walking the slot table one row per cycle) and emit, which
//  hands out the results, then goes idle or halts. One item is in work at a time.
//  A stalled receiver holds the current result and the block waits.
//  Reset clears all rows, counters and the owner to one. After an accepted
//  shutdown all items are taken and dropped until reset.
//  Results of one item are held in a small queue of 2*ROWS+1 entries.
`timescale 1ns / 1ps
module credit_slot_admission_controller
    import csac_pkg::*;
#(
    parameter int ROWS      = 4,
    parameter int MAX_STEPS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_event_owner,
    input  logic [31:0] i_event_seq,
    input  logic [31:0] i_request_id,
    input  logic [31:0] i_generation,
    input  logic [7:0]  i_slot_row,
    input  logic [15:0] i_target_steps,
    input  logic [15:0] i_credit_amount,
    input  logic [31:0] i_cancel_number,
    input  logic [32:0] i_seed_value,
    input  logic [31:0] i_flag_word,
    input  logic [31:0] i_spare_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_kind,
    output logic [31:0] o_seq_echo,
    output logic [31:0] o_request_out,
    output logic [31:0] o_generation_out,
    output logic [7:0]  o_row_out,
    output logic [31:0] o_commit_count,
    output logic [32:0] o_row_value,
    output logic [32:0] o_remaining,
    output logic [32:0] o_credit_out,
    output logic [32:0] o_cancel_out,
    output logic [3:0]  o_status,
    output logic        o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;
    t_res  w_head;

    assign o_cfg_ready = 1'b1;

    csac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stat      (w_stat),
        .i_out_ready (i_ready),
        .o_ready     (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    csac_dp #(.ROWS(ROWS), .MAX_STEPS(MAX_STEPS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_event_owner   (i_event_owner),
        .i_event_seq     (i_event_seq),
        .i_request_id    (i_request_id),
        .i_generation    (i_generation),
        .i_slot_row      (i_slot_row),
        .i_target_steps  (i_target_steps),
        .i_credit_amount (i_credit_amount),
        .i_cancel_number (i_cancel_number),
        .i_seed_value    (i_seed_value),
        .i_flag_word     (i_flag_word),
        .i_spare_word    (i_spare_word),
        .o_head          (w_head),
        .o_last          (o_last)
    );

    assign o_kind           = w_head.kind;
    assign o_seq_echo       = w_head.seq;
    assign o_request_out    = w_head.req;
    assign o_generation_out = w_head.gen;
    assign o_row_out        = w_head.row;
    assign o_commit_count   = w_head.commits;
    assign o_row_value      = w_head.value;
    assign o_remaining      = w_head.rem;
    assign o_credit_out     = w_head.credit;
    assign o_cancel_out     = w_head.cancel;
    assign o_status         = w_head.status;

`ifndef ASSERT_OFF
    a_no_out_while_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("result offered while taking items");
    a_shut_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == K_SHUT) |-> o_last) else $error("shutdown not last");
    a_quiet_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == K_QUIET) |-> o_last) else $error("quiescent not last");
`endif

endmodule

// File: sim/tb_credit_slot_admission_controller.sv
// Self-checking testbench for the credit slot admission controller.
`timescale 1ns / 1ps
module tb_credit_slot_admission_controller;
    import csac_pkg::*;

    localparam int NROWS = 4;
    localparam int MAXSTEPS = 256;
    localparam int SETTLE = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] ACT_UNKNOWN_HI = 3'd6;

    typedef struct {
        bit [2:0]  action;
        bit [15:0] owner;
        bit [31:0] seq;
        bit [31:0] req;
        bit [31:0] gen;
        bit [7:0]  row;
        bit [15:0] tgt;
        bit [15:0] cred;
        bit [31:0] cancel;
        bit [32:0] seed;
        bit [31:0] flag;
        bit [31:0] spare;
    } t_event_item;

    typedef struct {
        bit [3:0]  kind;
        bit [31:0] seq;
        bit [31:0] req;
        bit [31:0] gen;
        bit [7:0]  row;
        bit [31:0] commits;
        bit [32:0] value;
        bit [32:0] rem;
        bit [32:0] credit;
        bit [32:0] cancel;
        bit [3:0]  status;
        bit        last;
    } t_slot_result;

    typedef struct {
        longint seq, req, gen, row, target, credit, cancel, seed;
    } t_decoded;

    class t_slot_scoreboard;
        longint       owner;
        bit           active[NROWS];
        longint       req[NROWS], gen[NROWS], lastgen[NROWS], tgt[NROWS];
        longint       cred[NROWS], cmt[NROWS], val[NROWS], lcan[NROWS];
        bit [63:0]    prev[12];
        bit           have_prev;
        longint       last_seq, last_row;
        bit [31:0]    ticks, tcommits, tevents, tdups, tcancels;
        bit           halted;
        t_slot_result pending[$];
        int           errors;

        function new();
            owner = 1;
            for (int i = 0; i < NROWS; i++) begin
                active[i] = 0; req[i] = 0; gen[i] = 0; lastgen[i] = 0; tgt[i] = 0;
                cred[i] = 0; cmt[i] = 0; val[i] = 0; lcan[i] = 0;
            end
            foreach (prev[i]) prev[i] = 0;
            have_prev = 0; last_seq = 0; last_row = -1;
            ticks = 0; tcommits = 0; tevents = 0; tdups = 0; tcancels = 0;
            halted = 0; errors = 0;
        endfunction

        function bit row_ok(longint r);
            return r >= 0 && r < NROWS;
        endfunction

        function bit any_active();
            foreach (active[i]) if (active[i]) return 1;
            return 0;
        endfunction

        function void put(longint k, longint s, longint r, longint g, longint rw,
                          longint c, longint v, longint rm, longint cr, longint cn,
                          longint st);
            t_slot_result x;
            x.kind = k; x.seq = s; x.req = r; x.gen = g; x.row = rw; x.commits = c;
            x.value = v; x.rem = rm; x.credit = cr; x.cancel = cn; x.status = st;
            x.last = 0;
            pending.push_back(x);
        endfunction

        function void put_row(longint k, longint s, int i, longint cn, longint st);
            put(k, s, req[i], gen[i], i, cmt[i], val[i], tgt[i] - cmt[i], cred[i], cn, st);
        endfunction

        function void reject(t_decoded e, longint st);
            if (row_ok(e.row)) put_row(K_REJECT, e.seq, int'(e.row), e.cancel, st);
            else put(K_REJECT, e.seq, e.req, e.gen, e.row, 0, e.seed, e.target,
                     e.credit, e.cancel, st);
        endfunction

        function void do_admit(t_decoded e);
            int  got;
            bit  saw_free;
            got = -1;
            saw_free = 0;
            if (e.req <= 0 || e.gen <= 0 || e.row != -1 || e.target <= 0 ||
                e.target > MAXSTEPS || e.credit < 0 || e.credit > e.target ||
                e.seed < -64'sd2147483648 || e.seed > 64'sd2147483647 - e.target) begin
                reject(e, S_TARGET);
                return;
            end
            for (int i = 0; i < NROWS; i++)
                if (active[i] && (req[i] == e.req || gen[i] == e.gen)) begin
                    reject(e, S_BUSY);
                    return;
                end
            for (int i = 0; i < NROWS; i++) begin
                if (active[i]) continue;
                saw_free = 1;
                if (e.gen > lastgen[i]) begin
                    got = i;
                    break;
                end
            end
            if (got < 0) begin
                reject(e, saw_free ? S_GEN : S_FULL);
                return;
            end
            active[got] = 1; req[got] = e.req; gen[got] = e.gen; lastgen[got] = e.gen;
            tgt[got] = e.target; cred[got] = e.credit; cmt[got] = 0; val[got] = e.seed;
            lcan[got] = 0; last_row = got;
            put_row(K_ADMIT, e.seq, got, 0, S_OK);
        endfunction

        function void do_credit(t_decoded e);
            int r;
            r = int'(e.row);
            if (!row_ok(e.row)) begin reject(e, S_ROW); return; end
            if (!active[r]) begin reject(e, S_INACTIVE); return; end
            if (req[r] != e.req || gen[r] != e.gen) begin reject(e, S_GEN); return; end
            if (e.credit <= 0 || cred[r] + e.credit > tgt[r] - cmt[r]) begin
                reject(e, S_CREDIT);
                return;
            end
            cred[r] += e.credit;
            last_row = r;
            put_row(K_CREDIT, e.seq, r, 0, S_OK);
        endfunction

        function void do_cancel(t_decoded e);
            int r;
            bit match;
            r = int'(e.row);
            if (!row_ok(e.row)) begin reject(e, S_ROW); return; end
            match = req[r] == e.req && gen[r] == e.gen;
            if (!active[r]) begin reject(e, match ? S_INACTIVE : S_GEN); return; end
            if (!match) begin reject(e, S_GEN); return; end
            if (e.cancel <= 0 || e.cancel <= lcan[r]) begin reject(e, S_STALE_CAN); return; end
            lcan[r] = e.cancel;
            active[r] = 0;
            tcancels++;
            last_row = r;
            put_row(K_CANCEL, e.seq, r, e.cancel, S_OK);
            if (!any_active()) put_row(K_QUIET, e.seq, r, 0, S_OK);
        endfunction

        function void do_event(t_event_item it);
            bit [63:0] raw[12];
            t_decoded  e;
            bit        same;
            raw[0] = it.action; raw[1] = it.owner; raw[2] = it.seq; raw[3] = it.req;
            raw[4] = it.gen; raw[5] = it.row; raw[6] = it.tgt; raw[7] = it.cred;
            raw[8] = it.cancel; raw[9] = it.seed; raw[10] = it.flag; raw[11] = it.spare;
            e.seq = $signed(it.seq); e.req = $signed(it.req); e.gen = $signed(it.gen);
            e.row = $signed(it.row); e.target = $signed(it.tgt);
            e.credit = $signed(it.cred); e.cancel = $signed(it.cancel);
            e.seed = $signed(it.seed);
            if (longint'(it.owner) != owner) begin reject(e, S_OWNER); return; end
            same = 1;
            foreach (raw[i]) if (raw[i] != prev[i]) same = 0;
            if (have_prev && e.seq == last_seq && same) begin
                tdups++;
                if (row_ok(last_row)) put_row(K_DUP, e.seq, int'(last_row), e.cancel, S_DUP);
                else put(K_DUP, e.seq, e.req, e.gen, e.row, 0, e.seed, e.target,
                         e.credit, e.cancel, S_DUP);
                return;
            end
            if (e.seq <= last_seq) begin reject(e, S_STALE); return; end
            foreach (raw[i]) prev[i] = raw[i];
            have_prev = 1;
            last_seq = e.seq;
            last_row = e.row;
            tevents++;
            case (it.action)
                ACT_ADMIT:  do_admit(e);
                ACT_CREDIT: do_credit(e);
                ACT_CANCEL: do_cancel(e);
                ACT_SHUTDOWN: begin
                    if (any_active()) begin reject(e, S_BUSY); return; end
                    halted = 1;
                    put(K_SHUT, e.seq, 0, 0, -1, ticks, tcommits, tevents, tdups,
                        tcancels, S_OK);
                end
                default: reject(e, S_UNKNOWN);
            endcase
        endfunction

        function void do_tick();
            bit elig[NROWS];
            bit some;
            int qrow;
            some = 0;
            qrow = -1;
            for (int i = 0; i < NROWS; i++) begin
                elig[i] = active[i] && cred[i] > 0;
                if (elig[i]) some = 1;
            end
            if (!some) return;
            ticks++;
            for (int i = 0; i < NROWS; i++) begin
                if (!elig[i]) continue;
                val[i]++; cmt[i]++; cred[i]--;
                tcommits++;
                put_row(K_COMMIT, last_seq, i, 0, S_OK);
                if (cmt[i] == tgt[i]) begin
                    active[i] = 0;
                    qrow = i;
                    put_row(K_DONE, last_seq, i, 0, S_OK);
                end
            end
            if (qrow >= 0 && !any_active()) put_row(K_QUIET, last_seq, qrow, 0, S_OK);
        endfunction

        // Note an accepted input item and queue the results it causes.
        function void accept_item(t_event_item it);
            int start;
            if (halted) return;
            start = pending.size();
            if (it.action == ACT_TICK) do_tick();
            else if (it.action == ACT_BAD)
                put(K_REJECT, last_seq, 0, 0, -1, 0, 0, 0, 0, 0, S_MALFORMED);
            else do_event(it);
            if (pending.size() > start) pending[pending.size() - 1].last = 1;
        endfunction

        function bit field_ok(string name, bit [63:0] exp_v, bit [63:0] act_v);
            if (exp_v == act_v) return 1;
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
            return 0;
        endfunction

        function void check_result(t_slot_result a);
            t_slot_result x;
            bit ok;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d",
                         $time, a.kind);
                errors++;
                return;
            end
            x = pending.pop_front();
            ok = field_ok("kind", x.kind, a.kind);
            ok &= field_ok("seq_echo", x.seq, a.seq);
            ok &= field_ok("request_out", x.req, a.req);
            ok &= field_ok("generation_out", x.gen, a.gen);
            ok &= field_ok("row_out", x.row, a.row);
            ok &= field_ok("commit_count", x.commits, a.commits);
            ok &= field_ok("row_value", x.value, a.value);
            ok &= field_ok("remaining", x.rem, a.rem);
            ok &= field_ok("credit_out", x.credit, a.credit);
            ok &= field_ok("cancel_out", x.cancel, a.cancel);
            ok &= field_ok("status", x.status, a.status);
            ok &= field_ok("last", x.last, a.last);
            if (!ok) errors++;
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, o_ready;
    logic [2:0]  i_action;
    logic [15:0] i_event_owner;
    logic [31:0] i_event_seq, i_request_id, i_generation;
    logic [7:0]  i_slot_row;
    logic [15:0] i_target_steps, i_credit_amount;
    logic [31:0] i_cancel_number;
    logic [32:0] i_seed_value;
    logic [31:0] i_flag_word, i_spare_word;
    logic        i_cfg_valid, o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        o_valid, i_ready;
    logic [3:0]  o_kind, o_status;
    logic [31:0] o_seq_echo, o_request_out, o_generation_out, o_commit_count;
    logic [7:0]  o_row_out;
    logic [32:0] o_row_value, o_remaining, o_credit_out, o_cancel_out;
    logic        o_last;

    credit_slot_admission_controller #(.ROWS(NROWS), .MAX_STEPS(MAXSTEPS)) dut (.*);

    t_slot_scoreboard sb;
    t_event_item    last_sent;
    longint         seq_ctr;
    longint         req_ctr;
    longint         gen_ctr;
    int             idle_pct;
    int             stall_pct;
    int             cycles;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; i_valid = 0; i_cfg_valid = 0; i_cfg_data = 0; i_ready = 0;
        i_action = 0; i_event_owner = 0; i_event_seq = 0; i_request_id = 0;
        i_generation = 0; i_slot_row = 0; i_target_steps = 0; i_credit_amount = 0;
        i_cancel_number = 0; i_seed_value = 0; i_flag_word = 0; i_spare_word = 0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_slot_result a;
        if (i_rst_n && o_valid && i_ready) begin
            a.kind = o_kind; a.seq = o_seq_echo; a.req = o_request_out;
            a.gen = o_generation_out; a.row = o_row_out; a.commits = o_commit_count;
            a.value = o_row_value; a.rem = o_remaining; a.credit = o_credit_out;
            a.cancel = o_cancel_out; a.status = o_status; a.last = o_last;
            sb.check_result(a);
        end
    end

    task automatic send(t_event_item it);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_action <= it.action; i_event_owner <= it.owner; i_event_seq <= it.seq;
        i_request_id <= it.req; i_generation <= it.gen; i_slot_row <= it.row;
        i_target_steps <= it.tgt; i_credit_amount <= it.cred;
        i_cancel_number <= it.cancel; i_seed_value <= it.seed;
        i_flag_word <= it.flag; i_spare_word <= it.spare;
        do @(posedge i_clk); while (!o_ready);
        sb.accept_item(it);
        last_sent = it;
    endtask

    // Hold the sender off until every expected result is out and the table walk is over.
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_owner(bit [15:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.owner = v;
        i_cfg_valid <= 0;
    endtask

    function automatic bit [32:0] rand33();
        return {$urandom_range(1, 0) == 1, $urandom()};
    endfunction

    function automatic t_event_item base_item(bit [2:0] a);
        t_event_item it;
        if (sb.last_seq > seq_ctr) seq_ctr = sb.last_seq;
        seq_ctr += $urandom_range(1, 3);
        it.action = a; it.owner = sb.owner[15:0]; it.seq = seq_ctr;
        it.req = $urandom(); it.gen = $urandom(); it.row = $urandom();
        it.tgt = $urandom(); it.cred = $urandom(); it.cancel = $urandom();
        it.seed = rand33(); it.flag = $urandom(); it.spare = $urandom();
        return it;
    endfunction

    function automatic t_event_item dir_item(bit [2:0] a, longint row, longint rq,
                                             longint g, longint t, longint c,
                                             longint cn, longint sd);
        t_event_item it;
        it = base_item(a);
        it.row = row; it.req = rq; it.gen = g; it.tgt = t; it.cred = c;
        it.cancel = cn; it.seed = sd;
        return it;
    endfunction

    function automatic t_event_item good_admit();
        t_event_item it;
        bit [31:0]   s;
        it = base_item(ACT_ADMIT);
        req_ctr++;
        gen_ctr++;
        it.req = req_ctr; it.gen = gen_ctr; it.row = 8'hFF;
        it.tgt = ($urandom_range(19) == 0) ? MAXSTEPS : $urandom_range(1, 8);
        it.cred = $urandom_range(0, it.tgt);
        s = $urandom();
        it.seed = {s[31], s};
        return it;
    endfunction

    function automatic t_event_item row_item(bit [2:0] a);
        t_event_item it;
        int          i;
        longint      room;
        it = base_item(a);
        i = $urandom_range(0, NROWS - 1);
        it.row = i; it.req = sb.req[i]; it.gen = sb.gen[i];
        room = sb.tgt[i] - sb.cmt[i] - sb.cred[i];
        it.cred = (room > 0) ? $urandom_range(1, int'(room)) : 1;
        it.cancel = sb.lcan[i] + $urandom_range(1, 4);
        if ($urandom_range(9) == 0) it.cancel = sb.lcan[i];
        return it;
    endfunction

    function automatic t_event_item random_item();
        t_event_item it;
        int          r;
        r = $urandom_range(99);
        if (r < 30) it = base_item(ACT_TICK);
        else if (r < 48) it = good_admit();
        else if (r < 64) it = row_item(ACT_CREDIT);
        else if (r < 72) it = row_item(ACT_CANCEL);
        else if (r < 77) it = last_sent;
        else if (r < 81) begin
            it = base_item(ACT_CREDIT);
            it.seq = sb.last_seq - $urandom_range(0, 5);
        end else if (r < 85) begin
            it = base_item(ACT_ADMIT);
            it.owner = $urandom();
        end else if (r < 90) it = base_item($urandom_range(ACT_UNKNOWN_LO, ACT_BAD));
        else if (r < 92) it = base_item(ACT_SHUTDOWN);
        else begin
            // Fully random noise; keep the owner wrong so the sequence stays usable.
            it = base_item($urandom());
            it.seq = $urandom();
            it.owner = $urandom();
            if (it.owner == sb.owner[15:0]) it.owner[0] = ~it.owner[0];
            if (it.action == ACT_SHUTDOWN) it.action = ACT_ADMIT;
        end
        if (it.action == ACT_SHUTDOWN && sb.any_active() == 0) it.action = ACT_CANCEL;
        return it;
    endfunction

    initial begin
        t_event_item it;
        int          owners[4];
        sb = new();
        seq_ctr = 0; req_ctr = 100; gen_ctr = 100;
        idle_pct = 0; stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(base_item(ACT_BAD));
        send(base_item(ACT_UNKNOWN_LO));
        send(base_item(ACT_UNKNOWN_HI));
        send(base_item(ACT_TICK));
        send(dir_item(ACT_ADMIT, -1, 5, 5, 0, 0, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 5, 5, MAXSTEPS + 1, 0, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 5, 5, 4, 5, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 5, 5, 4, 1, 0, 64'sd2147483647));
        send(dir_item(ACT_ADMIT, 0, 5, 5, 4, 1, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 0, 5, 4, 1, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 1, 1, 1, 1, 0, 64'sd2147483646));
        send(base_item(ACT_TICK));
        send(dir_item(ACT_ADMIT, -1, 2, 1, 2, 2, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 3, 3, MAXSTEPS, 0, 0, -64'sd2147483648));
        send(dir_item(ACT_ADMIT, -1, 3, 4, 2, 0, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 6, 6, 2, 0, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 7, 7, 2, 0, 0, 0));
        send(dir_item(ACT_ADMIT, -1, 8, 8, 2, 0, 0, 0));
        send(last_sent);
        send(dir_item(ACT_CREDIT, 9, 3, 3, 0, 1, 0, 0));
        send(dir_item(ACT_CREDIT, 1, 3, 3, 0, MAXSTEPS + 1, 0, 0));
        send(dir_item(ACT_CREDIT, 0, 1, 9, 0, 1, 0, 0));
        send(dir_item(ACT_CANCEL, 1, 3, 3, 0, 0, 0, 0));
        send(dir_item(ACT_CANCEL, 1, 3, 3, 0, 0, 32'h7FFFFFFF, 0));
        send(dir_item(ACT_SHUTDOWN, -1, 0, 0, 0, 0, 0, 0));
        it = base_item(ACT_ADMIT);
        it.owner = 16'hFFFF;
        send(it);

        owners[0] = 16'hFFFF; owners[1] = 0; owners[2] = $urandom_range(2, 16'hFFFE);
        owners[3] = 1;
        for (int ph = 0; ph < 4; ph++) begin
            write_owner(owners[ph]);
            idle_pct = (ph == 1) ? 57 : (ph == 3) ? 35 : 0;
            stall_pct = (ph == 2) ? 57 : (ph == 3) ? 35 : 0;
            for (int n = 0; n < 30; n++) send(random_item());
        end

        // Retire what is left, then shut down on the largest sequence number.
        for (int i = 0; i < NROWS; i++)
            if (sb.active[i]) begin
                it = row_item(ACT_CANCEL);
                it.row = i; it.req = sb.req[i]; it.gen = sb.gen[i];
                it.cancel = sb.lcan[i] + 1;
                send(it);
            end
        it = base_item(ACT_SHUTDOWN);
        it.seq = 32'h7FFFFFFF;
        send(it);
        send(base_item(ACT_BAD));
        send(good_admit());
        send(base_item(ACT_TICK));
        drain();
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/csac_pkg.sv
rtl/core/csac_ctrl.sv
rtl/core/csac_dp.sv
rtl/core/credit_slot_admission_controller.sv
sim/tb_credit_slot_admission_controller.sv
